FILE: rtl/core/distinct_prime_factorizer_unit_macros.svh
// Assertion macros used by the factorizer datapath.
// Each macro takes a label, the clock, the reset and the property terms.
`ifndef DISTINCT_PRIME_FACTORIZER_UNIT_MACROS_SVH
`define DISTINCT_PRIME_FACTORIZER_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define DPF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("factorizer assertion failed");
// Next-cycle implication.
`define DPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("factorizer assertion failed");
`else
`define DPF_ASSERT_IMP(label, clk, rst, ante, cons)
`define DPF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/dpf_pkg.sv
`default_nettype none

package dpf_pkg;

   // Default width of the value to factor.
   localparam int VALUE_WIDTH_DEF = 32;

   // Results given for one word at most; later factors are dropped.
   localparam int MAX_RESULTS = 9;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   // Source of a factor that is pushed into the result queue.
   typedef enum logic [1:0] {
      PUSH_NONE,
      PUSH_TWO,
      PUSH_DIV,
      PUSH_REM
   } push_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         load;
      logic         shift2;
      push_sel_type push_sel;
      logic         div_start;
      logic         rem_from_q;
      logic         d_init;
      logic         d_step;
      logic         emit_final;
      logic         emit_bad;
   } dpf_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_small;
      logic out_free;
      logic rem_lsb;
      logic rem_gt2;
      logic div_done;
      logic bound_ok;
      logic r_zero;
   } dpf_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/distinct_prime_factorizer_unit.sv
`default_nettype none

// Factors each input word into its distinct primes by trial division and
// returns one output word per prime, ascending, with tlast on the final one;
// an input of 2 or less returns a single word with tuser set and factor zero.
// One word is worked on at a time. Each trial division runs through a
// one-bit-per-cycle divider; odd divisors are tried up to the square root of
// what remains. A result register sits on the output, so the next word is
// accepted while the last result still waits.
module distinct_prime_factorizer_unit import dpf_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // value
   input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]    req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // factor
   output logic [((VALUE_WIDTH+7)/8)*8-1:0]         rsp_tdata,
   // bad_input
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast
);

   localparam int DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;
   localparam int DIV_W  = VALUE_WIDTH / 2 + 2;

   dpf_cmd_type            cmd;
   dpf_status_type         status;
   logic [VALUE_WIDTH-1:0] factor;

   dpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dpf_dp #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DIV_W       (DIV_W)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_tdata[VALUE_WIDTH-1:0]),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_factor (factor),
      .rsp_bad    (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = DATA_W'(factor);

endmodule

`default_nettype wire

FILE: rtl/core/dpf_div.sv
`default_nettype none

// Restoring divider: one quotient bit per cycle.
module dpf_div import dpf_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int DIV_W       = VALUE_WIDTH / 2 + 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [VALUE_WIDTH-1:0] dividend,
   input  wire logic [DIV_W-1:0]       divisor,
   output logic                        done,
   output logic [VALUE_WIDTH-1:0]      quotient,
   output logic [DIV_W-1:0]            remainder
);

   localparam int CW = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0] quo_ff;
   logic [DIV_W-1:0]       part_ff;
   logic [DIV_W-1:0]       dsr_ff;
   logic [CW-1:0]          cnt_ff;
   logic                   busy_ff;
   logic                   done_ff;

   logic [DIV_W:0] trial;
   logic [DIV_W:0] diff;
   logic           fits;

   // Bring down the next dividend bit and try a subtract.
   always_comb begin
      trial = {part_ff, quo_ff[VALUE_WIDTH-1]};
      diff  = trial - {1'b0, dsr_ff};
      fits  = (trial >= {1'b0, dsr_ff});
   end

   // Control: busy while bits remain, done held until the next start.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CW'(VALUE_WIDTH);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Datapath: quotient bits shift in as dividend bits shift out.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff  <= dividend;
         part_ff <= '0;
         dsr_ff  <= divisor;
      end else if (busy_ff) begin
         quo_ff  <= {quo_ff[VALUE_WIDTH-2:0], fits};
         part_ff <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = part_ff;

endmodule

`default_nettype wire

FILE: rtl/core/dpf_dp.sv
`default_nettype none
`include "distinct_prime_factorizer_unit_macros.svh"

// Datapath: remaining value, trial divisor, held factor and result register.
module dpf_dp import dpf_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int DIV_W       = VALUE_WIDTH / 2 + 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [VALUE_WIDTH-1:0] req_value,
   input  wire dpf_cmd_type            cmd,
   output dpf_status_type              status,
   input  wire logic                   rsp_tready,
   output logic                        rsp_valid,
   output logic [VALUE_WIDTH-1:0]      rsp_factor,
   output logic                        rsp_bad,
   output logic                        rsp_last
);

   logic [VALUE_WIDTH-1:0] rem_ff;
   logic [DIV_W-1:0]       d_ff;
   logic [VALUE_WIDTH-1:0] pend_ff;
   logic                   pend_valid_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   rsp_valid_ff;
   logic [VALUE_WIDTH-1:0] rsp_factor_ff;
   logic                   rsp_bad_ff;
   logic                   rsp_last_ff;

   logic                   div_done;
   logic [VALUE_WIDTH-1:0] div_q;
   logic [DIV_W-1:0]       div_r;

   logic [VALUE_WIDTH-1:0] push_val;
   logic                   push_req;
   logic                   push_take;
   logic                   push_emit;
   logic                   out_load;

   dpf_div #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DIV_W       (DIV_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (rem_ff),
      .divisor   (d_ff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // Factor to push, by source.
   always_comb begin
      case (cmd.push_sel)
         PUSH_TWO: push_val = VALUE_WIDTH'(2);
         PUSH_DIV: push_val = VALUE_WIDTH'(d_ff);
         PUSH_REM: push_val = rem_ff;
         default:  push_val = '0;
      endcase
   end

   // A pushed factor is held back one step so that the final one can carry last.
   assign push_req  = (cmd.push_sel != PUSH_NONE);
   assign push_take = push_req && (cnt_ff < CNT_W'(MAX_RESULTS));
   assign push_emit = push_take && pend_valid_ff;
   assign out_load  = push_emit || cmd.emit_final || cmd.emit_bad;

   // Status for the controller.
   always_comb begin
      status.req_small = (req_value <= VALUE_WIDTH'(2));
      status.out_free  = !rsp_valid_ff || rsp_tready;
      status.rem_lsb   = rem_ff[0];
      status.rem_gt2   = (rem_ff > VALUE_WIDTH'(2));
      status.div_done  = div_done;
      status.bound_ok  = (VALUE_WIDTH'(d_ff) <= div_q);
      status.r_zero    = (div_r == '0);
   end

   // Remaining value and trial divisor.
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         d_ff   <= '0;
      end else begin
         if (cmd.load) begin
            rem_ff <= req_value;
         end else if (cmd.shift2) begin
            rem_ff <= rem_ff >> 1;
         end else if (cmd.rem_from_q) begin
            rem_ff <= div_q;
         end
         if (cmd.d_init) begin
            d_ff <= DIV_W'(3);
         end else if (cmd.d_step) begin
            d_ff <= d_ff + DIV_W'(2);
         end
      end
   end

   // Held factor and count of factors taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         cnt_ff        <= '0;
      end else if (cmd.load) begin
         pend_valid_ff <= 1'b0;
         cnt_ff        <= '0;
      end else if (push_take) begin
         pend_valid_ff <= 1'b1;
         cnt_ff        <= cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_take) begin
         pend_ff <= push_val;
      end
   end

   // Result register: loads when free, clears when the word is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_factor_ff <= cmd.emit_bad ? '0 : pend_ff;
         rsp_bad_ff    <= cmd.emit_bad;
         rsp_last_ff   <= cmd.emit_bad || cmd.emit_final;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_factor = rsp_factor_ff;
   assign rsp_bad    = rsp_bad_ff;
   assign rsp_last   = rsp_last_ff;

   // A word is never written over one that is still waiting.
   `DPF_ASSERT_IMP(a_load_free, clock, reset, out_load, !rsp_valid_ff || rsp_tready)
   // The closing word always has a held factor behind it.
   `DPF_ASSERT_IMP(a_final_pend, clock, reset, cmd.emit_final, pend_valid_ff)
   // An error word is alone, marked last and carries no factor.
   `DPF_ASSERT_IMP(a_bad_shape, clock, reset, rsp_valid_ff && rsp_bad_ff,
                   rsp_last_ff && (rsp_factor_ff == '0))

endmodule

`default_nettype wire

FILE: rtl/core/dpf_ctrl.sv
`default_nettype none

// Controller: sequences twos stripping, odd trial divisions and result words.
module dpf_ctrl import dpf_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire dpf_status_type status,
   output dpf_cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BAD,
      ST_STRIP_FIRST,
      ST_STRIP,
      ST_TEST_START,
      ST_TEST_WAIT,
      ST_OUT_START,
      ST_OUT_WAIT,
      ST_FLUSH,
      ST_FINAL
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.push_sel = PUSH_NONE;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = status.req_small ? ST_BAD : ST_STRIP_FIRST;
            end
         end
         ST_BAD: begin
            if (status.out_free) begin
               cmd.emit_bad = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         // First even check decides whether 2 is a factor.
         ST_STRIP_FIRST: begin
            if (status.rem_lsb) begin
               cmd.d_init = 1'b1;
               state_in   = ST_TEST_START;
            end else if (status.out_free) begin
               cmd.push_sel = PUSH_TWO;
               cmd.shift2   = 1'b1;
               state_in     = ST_STRIP;
            end
         end
         ST_STRIP: begin
            if (status.rem_lsb) begin
               cmd.d_init = 1'b1;
               state_in   = ST_TEST_START;
            end else begin
               cmd.shift2 = 1'b1;
            end
         end
         ST_TEST_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_TEST_WAIT;
         end
         // Divisor past the square root ends the trial loop.
         ST_TEST_WAIT: begin
            if (status.div_done) begin
               if (!status.bound_ok) begin
                  state_in = ST_FLUSH;
               end else if (status.r_zero) begin
                  if (status.out_free) begin
                     cmd.push_sel   = PUSH_DIV;
                     cmd.rem_from_q = 1'b1;
                     state_in       = ST_OUT_START;
                  end
               end else begin
                  cmd.d_step = 1'b1;
                  state_in   = ST_TEST_START;
               end
            end
         end
         ST_OUT_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_OUT_WAIT;
         end
         // Keep dividing out the same prime while it divides.
         ST_OUT_WAIT: begin
            if (status.div_done) begin
               if (status.r_zero) begin
                  cmd.rem_from_q = 1'b1;
                  state_in       = ST_OUT_START;
               end else begin
                  cmd.d_step = 1'b1;
                  state_in   = ST_TEST_START;
               end
            end
         end
         ST_FLUSH: begin
            if (!status.rem_gt2) begin
               state_in = ST_FINAL;
            end else if (status.out_free) begin
               cmd.push_sel = PUSH_REM;
               state_in     = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (status.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: tb/distinct_prime_factorizer_unit_tb.sv
`default_nettype none

module distinct_prime_factorizer_unit_tb;
   import dpf_pkg::*;

   localparam int VALUE_W     = VALUE_WIDTH_DEF;
   localparam int WORD_W      = ((VALUE_W + 7) / 8) * 8;
   localparam int RANDOM_ITEMS = 81;
   localparam int PAUSE_AT    = 60;
   localparam int HOLD_AT     = 40;
   localparam int HOLD_CYCLES = 3000;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT = 4_000_000;

   // One result word as the block should return it.
   typedef struct packed {
      logic [VALUE_W-1:0] factor;
      logic               bad_input;
      logic               last;
   } factor_word_type;

   // One row of the directed table. Rows with typed set carry their single
   // result word; the others go through the predictor.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               typed;
      logic [VALUE_W-1:0] factor;
      logic               bad_input;
   } stim_row_type;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_TOGGLE
   } ready_mode_type;

   localparam int NUM_ROWS = 19;
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // Values of two or less give one error word.
      '{32'd0,          1'b1, 32'd0,       1'b1},
      '{32'd1,          1'b1, 32'd0,       1'b1},
      '{32'd2,          1'b1, 32'd0,       1'b1},
      // Smallest odd prime and pure powers of two.
      '{32'd3,          1'b1, 32'd3,       1'b0},
      '{32'd4,          1'b1, 32'd2,       1'b0},
      '{32'd65536,      1'b1, 32'd2,       1'b0},
      '{32'h8000_0000,  1'b1, 32'd2,       1'b0},
      // Primes that end up as the leftover remainder.
      '{32'd65537,      1'b1, 32'd65537,   1'b0},
      '{32'd1000003,    1'b1, 32'd1000003, 1'b0},
      // Divisor squared equal to the remainder, and a remainder left over.
      '{32'd9,          1'b0, 32'd0,       1'b0},
      '{32'd15,         1'b0, 32'd0,       1'b0},
      '{32'd25,         1'b0, 32'd0,       1'b0},
      '{32'd147,        1'b0, 32'd0,       1'b0},
      '{32'd30,         1'b0, 32'd0,       1'b0},
      // Top of the range.
      '{32'hFFFF_FFFF,  1'b0, 32'd0,       1'b0},
      '{32'hFFFF_0000,  1'b0, 32'd0,       1'b0},
      '{32'd4294836225, 1'b0, 32'd0,       1'b0},
      // Nine distinct primes, the most a 32-bit value can have.
      '{32'd223092870,  1'b0, 32'd0,       1'b0},
      '{32'd4238764530, 1'b0, 32'd0,       1'b0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [WORD_W-1:0] req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [WORD_W-1:0] rsp_tdata;
   logic              rsp_tuser;
   logic              rsp_tlast;

   factor_word_type expected_factors[$];
   factor_word_type want;
   int           items_sent = 0;
   int           words_checked = 0;
   int           mismatches = 0;
   int           burst_left = 0;
   int           cycle_count = 0;

   distinct_prime_factorizer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Trial division on the testbench side, used only to build stimulus.
   function automatic bit is_prime(input int unsigned n);
      int unsigned d;
      if (n < 2) return 1'b0;
      for (d = 2; d * d <= n; d++)
         if (n % d == 0) return 1'b0;
      return 1'b1;
   endfunction

   // Works out the distinct prime factors of one word and queues the
   // result words the block should return for it.
   function automatic void predict_factors(input logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] cofactor;
      logic [VALUE_W-1:0] divisor;
      logic [VALUE_W-1:0] found[$];
      int                 count;
      if (value <= 2) begin
         expected_factors.push_back(factor_word_type'{'0, 1'b1, 1'b1});
         return;
      end
      cofactor = value;
      if (!cofactor[0]) begin
         found.push_back(2);
         while (!cofactor[0]) cofactor = cofactor >> 1;
      end
      // The bound is tested as divisor <= cofactor / divisor to stay exact.
      divisor = 3;
      while (divisor <= cofactor / divisor) begin
         if (cofactor % divisor == 0) begin
            found.push_back(divisor);
            while (cofactor % divisor == 0) cofactor = cofactor / divisor;
         end
         divisor += 2;
      end
      if (cofactor > 2) found.push_back(cofactor);
      // Factors past the result limit are dropped; the last kept one is marked.
      count = (found.size() > MAX_RESULTS) ? MAX_RESULTS : found.size();
      for (int i = 0; i < count; i++)
         expected_factors.push_back(factor_word_type'{found[i], 1'b0, i == count - 1});
   endfunction

   // Builds a value from small primes, sometimes one prime up to 65537, and a
   // power of two. The trial loop then ends by about 257, which keeps items short.
   function automatic logic [VALUE_W-1:0] smooth_value();
      longint unsigned v;
      int unsigned     p;
      int              shift;
      v = 1;
      if ($urandom_range(0, 2) == 0) begin
         p = $urandom_range(257, 65537);
         while (!is_prime(p)) p++;
         v = p;
      end
      repeat ($urandom_range(0, 8)) begin
         p = $urandom_range(3, 255);
         while (!is_prime(p)) p++;
         repeat ($urandom_range(1, 3))
            if (v * p <= 64'hFFFF_FFFF) v = v * p;
      end
      // Either fill up to the top bit or take a random shift below that.
      shift = 0;
      while (shift < 31 && (v << (shift + 1)) <= 64'hFFFF_FFFF) shift++;
      if ($urandom_range(0, 1) == 0) shift = $urandom_range(0, shift);
      return VALUE_W'(v << shift);
   endfunction

   task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                  input logic [VALUE_W-1:0] wanted);
      $display("mismatch on word %0d: %s got %0h want %0h",
               words_checked, what, got, wanted);
      mismatches++;
   endtask

   // Offers one word and waits for it to be taken. Words go out in bursts
   // with idle gaps between most of them.
   task automatic offer(input logic [VALUE_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = 0;
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 30);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            req_tdata <= $urandom();
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= WORD_W'(value);
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Input side: reset, the directed table, then random words.
   initial begin : stimulus
      stim_row_type       row;
      logic [VALUE_W-1:0] value;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         row = DIRECTED_ROWS[i];
         offer(row.value);
         if (row.typed)
            expected_factors.push_back(factor_word_type'{row.factor, row.bad_input, 1'b1});
         else
            predict_factors(row.value);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // Once, stop sending until every pending word has come back.
         if (i == PAUSE_AT) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (expected_factors.size() != 0);
         end
         if ($urandom_range(0, 9) == 0)
            value = $urandom_range(0, 2);
         else
            value = smooth_value();
         offer(value);
         predict_factors(value);
      end
      req_tvalid <= 1'b0;

      while (expected_factors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("distinct_prime_factorizer_unit_tb OK");
      else
         $display("distinct_prime_factorizer_unit_tb NOT OK");
      $finish;
   end

   // Result side: stall patterns that change at random, plus one
   // long hold-off that backs the block up into its input.
   initial begin : result_side
      int             seg_left;
      ready_mode_type mode;
      bit             held;
      seg_left = 0;
      mode = READY_ALWAYS;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && items_sent >= HOLD_AT) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (seg_left == 0) begin
            seg_left = $urandom_range(20, 200);
            mode = ready_mode_type'($urandom_range(0, 3));
         end
         seg_left--;
         case (mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:      rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   // Compare each returned word with the oldest pending one.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_factors.size() == 0) begin
            report_mismatch("word with nothing pending", rsp_tdata[VALUE_W-1:0], '0);
         end else begin
            want = expected_factors.pop_front();
            if (rsp_tdata[VALUE_W-1:0] !== want.factor)
               report_mismatch("factor", rsp_tdata[VALUE_W-1:0], want.factor);
            if (rsp_tuser !== want.bad_input)
               report_mismatch("bad_input", VALUE_W'(rsp_tuser), VALUE_W'(want.bad_input));
            if (rsp_tlast !== want.last)
               report_mismatch("last", VALUE_W'(rsp_tlast), VALUE_W'(want.last));
         end
         words_checked++;
      end
   end

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words pending",
                  cycle_count, expected_factors.size());
         $display("distinct_prime_factorizer_unit_tb NOT OK");
         $finish;
      end
   end

endmodule

`default_nettype wire

FILE: distinct_prime_factorizer_unit.f
+incdir+rtl/core
rtl/core/dpf_pkg.sv
rtl/core/dpf_div.sv
rtl/core/dpf_dp.sv
rtl/core/dpf_ctrl.sv
rtl/core/distinct_prime_factorizer_unit.sv
tb/distinct_prime_factorizer_unit_tb.sv
